// ===== sv/hst_pkg.sv =====
// Shared types and constants for the handle slot table.
// Used by the controller, the datapath, the top level and the checker.
package hst_pkg;

    // Default table geometry
    localparam int SLOT_COUNT_DEF  = 64;
    localparam int HANDLE_BITS_DEF = 32;

    // Fixed port field widths
    localparam int OP_W       = 2;
    localparam int SLOT_IDX_W = 6;
    localparam int HANDLE_W   = 32;
    localparam int STATUS_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_FIND   = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NULL  = 2'd3
    } status_t;

    // Where a scan starts
    typedef enum logic [1:0] {
        SEL_SP   = 2'd0,
        SEL_ZERO = 2'd1,
        SEL_HU   = 2'd2,
        SEL_IDX  = 2'd3
    } start_sel_t;

    // How the scan address moves and when issuing ends
    typedef enum logic [1:0] {
        SCAN_ONE      = 2'd0,
        SCAN_UP_WRAP  = 2'd1,
        SCAN_UP_TO_HU = 2'd2,
        SCAN_DOWN     = 2'd3
    } scan_mode_t;

    // Controller to datapath
    typedef struct packed {
        logic       clear;
        logic       load;
        logic       scan_start;
        start_sel_t start_sel;
        scan_mode_t mode;
        logic       scan_stop;
        logic       cap_slot;
        logic       cap_handle;
        logic       commit_put;
        logic       commit_remove;
        logic       set_hu;
        logic       publish;
        status_t    pub_status;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic null_h;
        logic full;
        logic in_range;
        logic rd_vld;
        logic data_zero;
        logic data_match;
        logic chk_at_hu;
        logic chk_at_zero;
        logic clr_last;
    } dp_stat_t;

endpackage

// ===== sv/hst_ctrl.sv =====
// Controller for the handle slot table: sequences clear, lookup, scans and result.
// Depends on hst_pkg for the command and status structs.
module hst_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  hst_pkg::dp_stat_t stat,
    output hst_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_LOOK,
        S_SCAN,
        S_TRIM,
        S_PUB
    } state_t;

    state_t           state_reg, state_next;
    hst_pkg::status_t code_reg, code_next;
    logic             out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Decode state and datapath status into commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        code_next  = code_reg;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                case (stat.op)
                    hst_pkg::OP_PUT:
                    begin
                        if (stat.null_h)
                        begin
                            code_next  = hst_pkg::ST_NULL;
                            state_next = S_PUB;
                        end
                        else if (stat.full)
                        begin
                            code_next  = hst_pkg::ST_FULL;
                            state_next = S_PUB;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            cmd.start_sel  = hst_pkg::SEL_SP;
                            cmd.mode       = hst_pkg::SCAN_UP_WRAP;
                            state_next     = S_SCAN;
                        end
                    end
                    hst_pkg::OP_FIND:
                    begin
                        if (stat.null_h)
                        begin
                            code_next  = hst_pkg::ST_NULL;
                            state_next = S_PUB;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            cmd.start_sel  = hst_pkg::SEL_ZERO;
                            cmd.mode       = hst_pkg::SCAN_UP_TO_HU;
                            state_next     = S_SCAN;
                        end
                    end
                    default:
                    begin
                        // get and remove read one addressed slot
                        if (stat.in_range)
                        begin
                            cmd.scan_start = 1'b1;
                            cmd.start_sel  = hst_pkg::SEL_IDX;
                            cmd.mode       = hst_pkg::SCAN_ONE;
                            state_next     = S_LOOK;
                        end
                        else
                        begin
                            code_next  = hst_pkg::ST_EMPTY;
                            state_next = S_PUB;
                        end
                    end
                endcase
            end

            S_LOOK:
            begin
                if (stat.rd_vld)
                begin
                    if (stat.data_zero)
                    begin
                        code_next  = hst_pkg::ST_EMPTY;
                        state_next = S_PUB;
                    end
                    else if (stat.op == hst_pkg::OP_REMOVE)
                    begin
                        // free the slot, then walk the highest-used mark down
                        cmd.cap_handle    = 1'b1;
                        cmd.commit_remove = 1'b1;
                        cmd.scan_start    = 1'b1;
                        cmd.start_sel     = hst_pkg::SEL_HU;
                        cmd.mode          = hst_pkg::SCAN_DOWN;
                        state_next        = S_TRIM;
                    end
                    else
                    begin
                        cmd.cap_handle = 1'b1;
                        code_next      = hst_pkg::ST_OK;
                        state_next     = S_PUB;
                    end
                end
            end

            S_SCAN:
            begin
                if (stat.rd_vld)
                begin
                    if (stat.op == hst_pkg::OP_PUT)
                    begin
                        if (stat.data_zero)
                        begin
                            cmd.commit_put = 1'b1;
                            cmd.cap_slot   = 1'b1;
                            cmd.scan_stop  = 1'b1;
                            code_next      = hst_pkg::ST_OK;
                            state_next     = S_PUB;
                        end
                    end
                    else if (stat.data_match)
                    begin
                        cmd.cap_slot  = 1'b1;
                        cmd.scan_stop = 1'b1;
                        code_next     = hst_pkg::ST_OK;
                        state_next    = S_PUB;
                    end
                    else if (stat.chk_at_hu)
                    begin
                        cmd.scan_stop = 1'b1;
                        code_next     = hst_pkg::ST_EMPTY;
                        state_next    = S_PUB;
                    end
                end
            end

            S_TRIM:
            begin
                if (stat.rd_vld && (!stat.data_zero || stat.chk_at_zero))
                begin
                    cmd.set_hu    = 1'b1;
                    cmd.scan_stop = 1'b1;
                    code_next     = hst_pkg::ST_OK;
                    state_next    = S_PUB;
                end
            end

            S_PUB:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish    = 1'b1;
                    cmd.pub_status = code_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            code_reg      <= hst_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/hst_dp.sv =====
// Datapath for the handle slot table: slot memory, scan address, marks and result.
// Depends on hst_pkg; driven by commands from hst_ctrl.
module hst_dp
#(
    parameter int SLOT_COUNT  = hst_pkg::SLOT_COUNT_DEF,
    parameter int HANDLE_BITS = hst_pkg::HANDLE_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [hst_pkg::OP_W-1:0]        opcode,
    input  logic [hst_pkg::SLOT_IDX_W-1:0]  slot_index,
    input  logic [hst_pkg::HANDLE_W-1:0]    handle_value,
    input  hst_pkg::dp_cmd_t                cmd,
    output hst_pkg::dp_stat_t               stat,
    output logic [hst_pkg::SLOT_IDX_W-1:0]  result_slot,
    output logic [hst_pkg::HANDLE_W-1:0]    result_handle,
    output logic [hst_pkg::STATUS_W-1:0]    status
);

    localparam int SW  = $clog2(SLOT_COUNT);
    localparam int CW  = $clog2(SLOT_COUNT + 1);
    localparam int HB  = HANDLE_BITS;
    localparam int IW  = hst_pkg::SLOT_IDX_W;
    localparam int HW  = hst_pkg::HANDLE_W;
    localparam int IXW = ((SW > IW) ? SW : IW) + 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

    // Slot memory
    logic [HB-1:0] mem [SLOT_COUNT];

    // Request
    hst_pkg::op_t op_reg;
    logic [SW-1:0] idx_reg;
    logic          in_range_reg;
    logic [HB-1:0] h_reg;

    // Scan
    logic [SW-1:0]       addr_reg;
    logic                live_reg;
    hst_pkg::scan_mode_t mode_reg;
    logic                rd_vld_reg;
    logic [SW-1:0]       chk_addr_reg;
    logic [HB-1:0]       rd_data_reg;

    // Table marks
    logic [SW-1:0] sp_reg;
    logic [SW-1:0] hu_reg;
    logic [CW-1:0] used_reg;

    // Pending and published result
    logic [SW-1:0]              pslot_reg;
    logic [HB-1:0]              phandle_reg;
    logic [IW-1:0]              result_slot_reg;
    logic [HW-1:0]              result_handle_reg;
    logic [hst_pkg::STATUS_W-1:0] status_reg;

    logic [HB+HW-1:0] h_wide;
    logic [HB-1:0]    h_in;
    logic [SW+IW-1:0] idx_wide;
    logic [SW-1:0]    idx_in;
    logic             in_range_in;
    logic [SW-1:0]    start_addr;
    logic [SW-1:0]    adv_addr;
    logic             last_issue;
    logic             mem_we;
    logic [SW-1:0]    mem_waddr;
    logic [HB-1:0]    mem_wdata;
    logic             rd_en;
    logic [IW+SW-1:0] slot_wide;
    logic [HW+HB-1:0] handle_wide;

    // Fit request fields to internal widths
    assign h_wide      = {{HB{1'b0}}, handle_value};
    assign h_in        = h_wide[HB-1:0];
    assign idx_wide    = {{SW{1'b0}}, slot_index};
    assign idx_in      = idx_wide[SW-1:0];
    assign in_range_in = (IXW'(slot_index) < IXW'(SLOT_COUNT));

    // Pick scan start
    always_comb
    begin
        case (cmd.start_sel)
            hst_pkg::SEL_SP:  start_addr = sp_reg;
            hst_pkg::SEL_HU:  start_addr = hu_reg;
            hst_pkg::SEL_IDX: start_addr = idx_reg;
            default:          start_addr = '0;
        endcase
    end

    // Advance the scan address and spot the final issue
    always_comb
    begin
        case (mode_reg)
            hst_pkg::SCAN_DOWN:
            begin
                adv_addr   = addr_reg - SW'(1);
                last_issue = (addr_reg == '0);
            end
            hst_pkg::SCAN_UP_WRAP:
            begin
                adv_addr   = (addr_reg == LAST_SLOT) ? '0 : addr_reg + SW'(1);
                last_issue = 1'b0;
            end
            hst_pkg::SCAN_UP_TO_HU:
            begin
                adv_addr   = addr_reg + SW'(1);
                last_issue = (addr_reg == hu_reg);
            end
            default:
            begin
                adv_addr   = addr_reg + SW'(1);
                last_issue = 1'b1;
            end
        endcase
    end

    // Memory port selection
    assign mem_we    = cmd.clear | cmd.commit_put | cmd.commit_remove;
    assign mem_waddr = cmd.clear ? addr_reg : chk_addr_reg;
    assign mem_wdata = cmd.commit_put ? h_reg : '0;
    assign rd_en     = live_reg & ~cmd.scan_stop;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[addr_reg];
            chk_addr_reg <= addr_reg;
        end
    end

    // Latch request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg      <= idx_in;
            in_range_reg <= in_range_in;
            h_reg        <= h_in;
        end
        if (cmd.publish)
        begin
            result_slot_reg   <= slot_wide[IW-1:0];
            result_handle_reg <= handle_wide[HW-1:0];
            status_reg        <= cmd.pub_status;
        end
    end

    // Control and table state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg      <= hst_pkg::OP_PUT;
            addr_reg    <= '0;
            live_reg    <= 1'b0;
            mode_reg    <= hst_pkg::SCAN_ONE;
            rd_vld_reg  <= 1'b0;
            sp_reg      <= '0;
            hu_reg      <= '0;
            used_reg    <= '0;
            pslot_reg   <= '0;
            phandle_reg <= '0;
        end
        else
        begin
            rd_vld_reg <= rd_en;

            if (cmd.clear)
            begin
                addr_reg <= addr_reg + SW'(1);
            end
            else if (cmd.scan_start)
            begin
                addr_reg <= start_addr;
                live_reg <= 1'b1;
                mode_reg <= cmd.mode;
            end
            else if (live_reg)
            begin
                if (cmd.scan_stop)
                begin
                    live_reg <= 1'b0;
                end
                else
                begin
                    addr_reg <= adv_addr;
                    live_reg <= ~last_issue;
                end
            end

            if (cmd.load)
            begin
                op_reg      <= hst_pkg::op_t'(opcode);
                pslot_reg   <= '0;
                phandle_reg <= '0;
            end
            if (cmd.cap_slot)
            begin
                pslot_reg <= chk_addr_reg;
            end
            if (cmd.cap_handle)
            begin
                phandle_reg <= rd_data_reg;
            end

            // Allocate: move the search pointer and raise the mark
            if (cmd.commit_put)
            begin
                sp_reg   <= chk_addr_reg;
                used_reg <= used_reg + CW'(1);
                if (chk_addr_reg > hu_reg)
                begin
                    hu_reg <= chk_addr_reg;
                end
            end
            if (cmd.commit_remove)
            begin
                used_reg <= used_reg - CW'(1);
            end
            if (cmd.set_hu)
            begin
                hu_reg <= chk_addr_reg;
            end
        end
    end

    // Status to the controller
    always_comb
    begin
        stat.op          = op_reg;
        stat.null_h      = (h_reg == '0);
        stat.full        = (used_reg == CW'(SLOT_COUNT));
        stat.in_range    = in_range_reg;
        stat.rd_vld      = rd_vld_reg;
        stat.data_zero   = (rd_data_reg == '0);
        stat.data_match  = (rd_data_reg == h_reg);
        stat.chk_at_hu   = (chk_addr_reg == hu_reg);
        stat.chk_at_zero = (chk_addr_reg == '0);
        stat.clr_last    = (addr_reg == LAST_SLOT);
    end

    // Fit result fields to port widths
    assign slot_wide   = {{IW{1'b0}}, pslot_reg};
    assign handle_wide = {{HW{1'b0}}, phandle_reg};

    assign result_slot   = result_slot_reg;
    assign result_handle = result_handle_reg;
    assign status        = status_reg;

endmodule

// ===== sv/handle_slot_table_top.sv =====
// Top level of the handle slot table: controller plus datapath.
// Depends on hst_pkg, hst_ctrl and hst_dp.
//
//   channel   handshake            payload
//   request   in_valid / in_ready  opcode, slot_index, handle_value
//   result    out_valid/ out_ready result_slot, result_handle, status
//
// One request at a time. Put probes slots from the search pointer, find reads
// slots up from slot 0, and remove walks slots down from the mark; a null or full
// put and a null find probe no slot.
// The slot memory gives one read a cycle.
// After reset the memory is zeroed one slot a cycle, with in_ready low. A stalled
// result sits in the output register; the next request is taken meanwhile and its
// result waits until the register frees.
module handle_slot_table_top
#(
    parameter int SLOT_COUNT  = hst_pkg::SLOT_COUNT_DEF,
    parameter int HANDLE_BITS = hst_pkg::HANDLE_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [hst_pkg::OP_W-1:0]        opcode,
    input  logic [hst_pkg::SLOT_IDX_W-1:0]  slot_index,
    input  logic [hst_pkg::HANDLE_W-1:0]    handle_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [hst_pkg::SLOT_IDX_W-1:0]  result_slot,
    output logic [hst_pkg::HANDLE_W-1:0]    result_handle,
    output logic [hst_pkg::STATUS_W-1:0]    status
);

    hst_pkg::dp_cmd_t  cmd;
    hst_pkg::dp_stat_t stat;

    // Sequence requests
    hst_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the table and build results
    hst_dp
    #(
        .SLOT_COUNT  (SLOT_COUNT),
        .HANDLE_BITS (HANDLE_BITS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .opcode        (opcode),
        .slot_index    (slot_index),
        .handle_value  (handle_value),
        .cmd           (cmd),
        .stat          (stat),
        .result_slot   (result_slot),
        .result_handle (result_handle),
        .status        (status)
    );

endmodule

// ===== sv/hst_check.sv =====
// Port-level checks for the handle slot table, bound to the top level.
// Depends on hst_pkg for status codes.
module hst_check
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [hst_pkg::OP_W-1:0]        opcode,
    input logic [hst_pkg::SLOT_IDX_W-1:0]  slot_index,
    input logic [hst_pkg::HANDLE_W-1:0]    handle_value,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [hst_pkg::SLOT_IDX_W-1:0]  result_slot,
    input logic [hst_pkg::HANDLE_W-1:0]    result_handle,
    input logic [hst_pkg::STATUS_W-1:0]    status
);

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_slot)
            && $stable(result_handle) && $stable(status))
        else $error("stalled result changed");

    // Hold a waiting request
    a_request_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(opcode)
            && $stable(slot_index) && $stable(handle_value))
        else $error("waiting request changed");

    // Zero the payload of every failed request
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != hst_pkg::ST_OK) |-> (result_slot == '0)
            && (result_handle == '0))
        else $error("failed request carries a nonzero payload");

    // Drop ready after an accepted request
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while one is in work");

endmodule

bind handle_slot_table_top hst_check u_check
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .slot_index    (slot_index),
    .handle_value  (handle_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_slot   (result_slot),
    .result_handle (result_handle),
    .status        (status)
);
